// File: src/spq_pkg.sv
// Shared definitions for the sorted priority queue: capacity, widths,
// operation and status codes, controller state and command types.
// No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 5;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // apply the held item and load the result register
  } ctrl_cmd_t;

endpackage

// File: src/sorted_priority_queue.sv
// Top level of the sorted priority queue: joins controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
// Usage: each input transfer carries one operation (enqueue, dequeue, or
// peek; code three acts as peek) with a payload and a key. Entries are kept
// sorted by ascending signed key; equal keys leave in arrival order.
// Every input transfer yields exactly one output transfer with the head
// entry after the operation (zeros when empty), a head-valid flag, the
// status (ok, empty on dequeue or peek, full with the enqueue dropped) and
// the low five bits of the occupancy.
// The controller captures an accepted item in the item register, then in
// its execute step applies the item to the cells, shifting the whole cell
// row at once, and loads the result register with the outcome.
// The input stalls while an item is held for execution. A finished result
// sits in an output register, so the next item is taken while the
// receiver stalls; execution of that item waits until the register frees.
// Reset clears the occupancy and the controller; cell contents are left
// as they are and never read before being written. No clearing pass.
module sorted_priority_queue import spq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic signed [WORD_W-1:0] data_value_i,
  input  logic signed [WORD_W-1:0] priority_key_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] front_data_o,
  output logic signed [WORD_W-1:0] front_priority_o,
  output logic                     front_valid_o,
  output logic [1:0]               status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  ctrl_cmd_t cmd;

  // sequence: capture the item, then execute once the result slot is free
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // hold the sorted cells and the result register
  spq_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .op_i             (op_i),
    .data_value_i     (data_value_i),
    .priority_key_i   (priority_key_i),
    .front_data_o     (front_data_o),
    .front_priority_o (front_priority_o),
    .front_valid_o    (front_valid_o),
    .status_o         (status_o),
    .occupancy_o      (occupancy_o)
  );

  // an accepted item blocks the input until it has executed
  a_hold_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !cmd.load))
    else $error("input accepted while an item is still held");

  // execution loads the result register, so valid must follow
  a_exec_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_valid_o)
    else $error("execution did not present a result");

  // a full rejection implies a nonempty head
  a_full_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> front_valid_o)
    else $error("full status with empty head");

  // an empty report implies no head entry
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (!front_valid_o && occupancy_o == '0))
    else $error("empty status with a head entry");

endmodule

// File: src/spq_ctrl.sv
// Controller of the sorted priority queue: sequences capture and execution
// of one item and owns the result-valid flag. Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    // the result slot frees up when empty or when its transfer completes now
    out_free   = !out_valid_q || !out_stall_i;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.exec || (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/spq_dpath.sv
// Datapath of the sorted priority queue: item register, a row of sorted
// cells with occupancy count, and the result register. Depends on spq_pkg.
module spq_dpath import spq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  input  logic [1:0]               op_i,
  input  logic signed [WORD_W-1:0] data_value_i,
  input  logic signed [WORD_W-1:0] priority_key_i,
  output logic signed [WORD_W-1:0] front_data_o,
  output logic signed [WORD_W-1:0] front_priority_o,
  output logic                     front_valid_o,
  output logic [1:0]               status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  // held item
  logic [1:0]               op_q;
  logic signed [WORD_W-1:0] data_q;
  logic signed [WORD_W-1:0] key_q;

  // sorted cells, head at index 0
  logic signed [WORD_W-1:0] cdata_q [DEPTH];
  logic signed [WORD_W-1:0] cdata_d [DEPTH];
  logic signed [WORD_W-1:0] cprio_q [DEPTH];
  logic signed [WORD_W-1:0] cprio_d [DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;

  // result register
  logic signed [WORD_W-1:0] fdata_q, fprio_q;
  logic                     fvalid_q;
  logic [1:0]               status_q, status_d;
  logic [OCC_W-1:0]         occ_q;

  logic             is_full, is_empty, do_enq, do_deq;
  logic [DEPTH-1:0] after;  // cell lies at or behind the insertion point
  logic [DEPTH-1:0] first;  // cell is the insertion point

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign do_enq   = cmd_i.exec && (op_q == OP_ENQ) && !is_full;
  assign do_deq   = cmd_i.exec && (op_q == OP_DEQ) && !is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign after[i] = (CNT_W'(i) >= count_q) || (cprio_q[i] > key_q);
    if (i == 0) begin : g_head
      assign first[i] = after[i];
    end else begin : g_body
      assign first[i] = after[i] && !after[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cdata_d[i] = cdata_q[i];
      cprio_d[i] = cprio_q[i];
      if (do_enq) begin
        if (first[i]) begin
          cdata_d[i] = data_q;
          cprio_d[i] = key_q;
        end else if (after[i] && i > 0) begin
          cdata_d[i] = cdata_q[(i > 0) ? i - 1 : 0];
          cprio_d[i] = cprio_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_deq && i < DEPTH - 1) begin
        cdata_d[i] = cdata_q[(i < DEPTH - 1) ? i + 1 : i];
        cprio_d[i] = cprio_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_deq) begin
      count_d = count_q - CNT_W'(1);
    end
    case (op_q)
      OP_ENQ:  status_d = is_full ? ST_FULL : ST_OK;
      default: status_d = is_empty ? ST_EMPTY : ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      data_q <= data_value_i;
      key_q  <= priority_key_i;
    end
    for (int i = 0; i < DEPTH; i++) begin
      cdata_q[i] <= cdata_d[i];
      cprio_q[i] <= cprio_d[i];
    end
    if (cmd_i.exec) begin
      fvalid_q <= (count_d != '0);
      fdata_q  <= (count_d != '0) ? cdata_d[0] : '0;
      fprio_q  <= (count_d != '0) ? cprio_d[0] : '0;
      status_q <= status_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign front_data_o     = fdata_q;
  assign front_priority_o = fprio_q;
  assign front_valid_o    = fvalid_q;
  assign status_o         = status_q;
  assign occupancy_o      = occ_q;

endmodule
